@@ sv/bdh_pkg.sv @@
// Shared types and constants for the button debounce / hold detector.
// No dependencies; every other file depends on this package.
package bdh_pkg;

    // Width of the free-running millisecond timestamp
    localparam int TIME_WIDTH = 32;

    // Widths of the configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 2'd2;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_MS_RST = 16'd20;
    localparam logic [15:0] HOLD_MS_RST     = 16'd600;

    // Reported button status
    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_HOLD     = 2'd2
    } t_status;

    // Current register settings
    typedef struct packed {
        logic        active_level;
        logic [15:0] debounce_ms;
        logic [15:0] hold_ms;
    } t_cfg;

endpackage

@@ sv/bdh_if.sv @@
// Valid/ready channel interfaces: pin samples, status words and register writes.
// Depends on bdh_pkg for widths.

interface bdh_in_if;
    logic                          valid;
    logic                          ready;
    logic                          pin_level;
    logic [bdh_pkg::TIME_WIDTH-1:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdh_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] button_status;

    modport source (output valid, output button_status, input ready);
    modport sink   (input valid, input button_status, output ready);
endinterface

interface bdh_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bdh_pkg::CFG_IDX_W-1:0]  index;
    logic [bdh_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/button_debounce_hold_detect.sv @@
// Button debounce with hold detection. Each accepted word is one pin sample
// with a millisecond timestamp and yields one status word (released, pressed,
// hold). A word is taken every cycle while the skid entry is empty: the
// debounce and hold compares are one 32-bit subtract and compare each, done
// in the cycle the sample is accepted, and the status goes to an output
// register backed by one skid entry. Input ready drops only while both output
// entries are full. Register writes are always taken.
// Depends on bdh_pkg, the channel interfaces and bdh_cfg_regs.
module button_debounce_hold_detect (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bdh_in_if.sink   i_in,
    bdh_out_if.source o_out,
    bdh_cfg_if.sink  i_cfg
);
    import bdh_pkg::*;

    t_cfg                  w_cfg;
    logic                  w_accept;
    logic                  w_out_fire;
    logic                  w_active;
    logic [TIME_WIDTH-1:0] w_db_elapsed;
    logic [TIME_WIDTH-1:0] w_act_elapsed;
    logic                  w_db_done;
    logic                  w_hold_done;

    logic                  r_is_pressed, n_is_pressed;
    t_status               r_status, n_status;
    logic                  r_db_running, n_db_running;
    logic [TIME_WIDTH-1:0] r_db_start, n_db_start;
    logic [TIME_WIDTH-1:0] r_act_start, n_act_start;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic                  r_skid_valid;
    t_status               r_skid_status;

    bdh_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign i_in.ready = !r_skid_valid;
    assign w_accept   = i_in.valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && o_out.ready;

    // Modular elapsed times, compared against zero-extended settings
    assign w_active      = (i_in.pin_level == w_cfg.active_level);
    assign w_db_elapsed  = i_in.now_ms - r_db_start;
    assign w_act_elapsed = i_in.now_ms - r_act_start;
    assign w_db_done     = w_db_elapsed >= TIME_WIDTH'(w_cfg.debounce_ms);
    assign w_hold_done   = w_act_elapsed >= TIME_WIDTH'(w_cfg.hold_ms);

    // Next debounce state for the current sample
    always_comb begin
        n_is_pressed = r_is_pressed;
        n_status     = r_status;
        n_db_running = r_db_running;
        n_db_start   = r_db_start;
        n_act_start  = r_act_start;
        if (!r_is_pressed) begin
            if (w_active) begin
                if (!r_db_running) begin
                    n_db_running = 1'b1;
                    n_db_start   = i_in.now_ms;
                    n_act_start  = i_in.now_ms;
                end else if (w_db_done) begin
                    n_db_running = 1'b0;
                    n_db_start   = '0;
                    n_is_pressed = 1'b1;
                    n_status     = ST_PRESSED;
                end
            end else begin
                n_db_running = 1'b0;
                n_db_start   = '0;
                n_act_start  = '0;
            end
        end else begin
            if (!w_active) begin
                if (!r_db_running) begin
                    n_db_running = 1'b1;
                    n_db_start   = i_in.now_ms;
                end else if (w_db_done) begin
                    n_db_running = 1'b0;
                    n_db_start   = '0;
                    n_act_start  = '0;
                    n_is_pressed = 1'b0;
                    n_status     = ST_RELEASED;
                end
            end else begin
                // Active sample drops a pending release and checks hold
                n_db_running = 1'b0;
                n_db_start   = '0;
                if (w_hold_done) begin
                    n_status = ST_HOLD;
                end
            end
        end
    end

    // Advance state on each accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_pressed <= 1'b0;
            r_status     <= ST_RELEASED;
            r_db_running <= 1'b0;
            r_db_start   <= '0;
            r_act_start  <= '0;
        end else if (w_accept) begin
            r_is_pressed <= n_is_pressed;
            r_status     <= n_status;
            r_db_running <= n_db_running;
            r_db_start   <= n_db_start;
            r_act_start  <= n_act_start;
        end
    end

    // Output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload of the output entries
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_status <= r_skid_status;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_status <= n_status;
            end else begin
                r_skid_status <= n_status;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.button_status = r_out_status;

`ifndef SYNTHESIS
    // The skid entry fills only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // A drained skid entry moves into the output register
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_out_fire) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry lost on drain");

    // Pressed or hold status only while the press is accepted
    a_status_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != ST_RELEASED) |-> r_is_pressed)
        else $error("pressed status without accepted press");

    // Hold is left only through an accepted release
    a_hold_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status == ST_HOLD) |=> (r_status == ST_HOLD || r_status == ST_RELEASED))
        else $error("hold status dropped to pressed");
`endif

endmodule

@@ sv/bdh_cfg_regs.sv @@
// Configuration register file: active level, debounce time, hold time.
// Depends on bdh_pkg and bdh_cfg_if.
module bdh_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bdh_cfg_if.sink          i_cfg,
    output bdh_pkg::t_cfg    o_cfg
);
    import bdh_pkg::*;

    logic        r_active_level;
    logic [15:0] r_debounce_ms;
    logic [15:0] r_hold_ms;
    logic        w_wr;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    // Update the addressed register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= 1'b0;
            r_debounce_ms  <= DEBOUNCE_MS_RST;
            r_hold_ms      <= HOLD_MS_RST;
        end else if (w_wr) begin
            case (i_cfg.index)
                REG_ACTIVE_LEVEL: r_active_level <= i_cfg.data[0];
                REG_DEBOUNCE_MS:  r_debounce_ms  <= i_cfg.data[15:0];
                REG_HOLD_MS:      r_hold_ms      <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.active_level = r_active_level;
    assign o_cfg.debounce_ms  = r_debounce_ms;
    assign o_cfg.hold_ms      = r_hold_ms;

endmodule
